### hw/rtl/svdp_pkg.sv
// Shared types and constants for the sparse vector dot product block.
package svdp_pkg;

	localparam int POS_W = 16;
	localparam int VAL_W = 16;
	localparam int PROD_W = 2 * VAL_W;
	localparam int ACC_W = 48;
	localparam int MCNT_W = 9;

	localparam logic [1:0] ACT_APPEND_A = 2'd0;
	localparam logic [1:0] ACT_APPEND_B = 2'd1;
	localparam logic [1:0] ACT_COMPUTE = 2'd2;

	typedef struct packed {
		logic [POS_W-1:0] pos;
		logic [VAL_W-1:0] val;
	} pair_t;

	typedef struct packed {
		logic clear;
		logic fire;
	} mac_ctl_t;

endpackage

### hw/rtl/sparse_vector_dot_product_top.sv
// Sparse vector dot product top level: list stores, merge walk sequencer, result register.
//
// Items with action 0 or 1 append a (position, value) pair to list a or b and are taken
// back to back; a full list drops the pair and sets a sticky flag that only reset clears.
// A compute item (action 2) walks both lists in merge order, one merge step per cycle
// through the registered read ports of the two list memories; no further item is taken
// until it is done. It takes S merge steps (at most len_a + len_b - 1, zero when either
// list is empty) plus the first read, the multiplier register and loading the result
// register. The result waits in its own register while appends for the next vectors are
// taken; a further compute item walks, but its result is not loaded until the earlier one
// has gone. Action 3 is accepted and ignored. No clearing pass is needed after reset.
module sparse_vector_dot_product_top
	import svdp_pkg::*;
#(
	parameter int MAX_NONZEROS = 256
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    item_valid,
	output logic                    item_ready,
	input  logic [1:0]              action,
	input  logic [POS_W-1:0]        position,
	input  logic signed [VAL_W-1:0] element_value,
	output logic                    result_valid,
	input  logic                    result_ready,
	output logic signed [ACC_W-1:0] dot_product,
	output logic [MCNT_W-1:0]       match_count,
	output logic                    dropped_flag
);

	localparam int AW = (MAX_NONZEROS > 1) ? $clog2(MAX_NONZEROS) : 1;
	localparam int CW = $clog2(MAX_NONZEROS + 1);
	localparam logic [CW-1:0] MAX_LEN = CW'(MAX_NONZEROS);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_WALK  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_EMIT  = 2'd3;

	logic [1:0]    state_q;
	logic [CW-1:0] len_a_q, len_b_q;
	logic [CW-1:0] i_q, j_q, i_nxt, j_nxt;
	logic          sticky_q;
	logic          res_vld_q;

	logic          take, is_compute, app_a, app_b, wr_a, wr_b;
	logic          walking, pos_eq, walk_end, load_res;
	pair_t         wpair, rd_a, rd_b;
	mac_ctl_t      mac_ctl;
	logic signed [ACC_W-1:0] acc;
	logic [MCNT_W-1:0]       match_cnt;

	assign item_ready = (state_q == ST_IDLE);
	assign take       = item_valid && item_ready;
	assign is_compute = take && (action == ACT_COMPUTE);
	assign app_a      = take && (action == ACT_APPEND_A);
	assign app_b      = take && (action == ACT_APPEND_B);
	assign wr_a       = app_a && (len_a_q < MAX_LEN);
	assign wr_b       = app_b && (len_b_q < MAX_LEN);
	assign wpair      = '{pos: position, val: element_value};

	assign walking = (state_q == ST_WALK);
	assign pos_eq  = (rd_a.pos == rd_b.pos);

	// next indices drive the read ports directly, so read data always matches i_q/j_q
	always_comb begin
		i_nxt = i_q;
		j_nxt = j_q;
		if (is_compute) begin
			i_nxt = '0;
			j_nxt = '0;
		end else if (walking) begin
			priority if (pos_eq) begin
				i_nxt = i_q + CW'(1);
				j_nxt = j_q + CW'(1);
			end else if (rd_a.pos < rd_b.pos) begin
				i_nxt = i_q + CW'(1);
			end else begin
				j_nxt = j_q + CW'(1);
			end
		end
	end

	assign walk_end = (i_nxt >= len_a_q) || (j_nxt >= len_b_q);
	assign load_res = (state_q == ST_EMIT) && (!res_vld_q || result_ready);

	assign mac_ctl.clear = is_compute;
	assign mac_ctl.fire  = walking && pos_eq;

	svdp_list_mem #(
		.DEPTH(MAX_NONZEROS),
		.AW   (AW)
	) u_list_a (
		.clk  (clk),
		.we   (wr_a),
		.waddr(len_a_q[AW-1:0]),
		.wdata(wpair),
		.raddr(i_nxt[AW-1:0]),
		.rdata(rd_a)
	);

	svdp_list_mem #(
		.DEPTH(MAX_NONZEROS),
		.AW   (AW)
	) u_list_b (
		.clk  (clk),
		.we   (wr_b),
		.waddr(len_b_q[AW-1:0]),
		.wdata(wpair),
		.raddr(j_nxt[AW-1:0]),
		.rdata(rd_b)
	);

	svdp_mac u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (mac_ctl),
		.va       (rd_a.val),
		.vb       (rd_b.val),
		.acc      (acc),
		.match_cnt(match_cnt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			len_a_q   <= '0;
			len_b_q   <= '0;
			i_q       <= '0;
			j_q       <= '0;
			sticky_q  <= 1'b0;
			res_vld_q <= 1'b0;
		end else begin
			i_q <= i_nxt;
			j_q <= j_nxt;
			if (wr_a) begin
				len_a_q <= len_a_q + CW'(1);
			end
			if (wr_b) begin
				len_b_q <= len_b_q + CW'(1);
			end
			if ((app_a && !wr_a) || (app_b && !wr_b)) begin
				sticky_q <= 1'b1;
			end
			if (load_res) begin
				res_vld_q <= 1'b1;
				len_a_q   <= '0;
				len_b_q   <= '0;
			end else if (result_ready) begin
				res_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (is_compute) begin
						state_q <= ((len_a_q == '0) || (len_b_q == '0)) ? ST_DRAIN : ST_WALK;
					end
				end
				ST_WALK: begin
					if (walk_end) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					// last product lands in the accumulator here
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (load_res) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			dot_product  <= acc;
			match_count  <= match_cnt;
			dropped_flag <= sticky_q;
		end
	end

	assign result_valid = res_vld_q;

endmodule

### hw/rtl/svdp_list_mem.sv
// One list store: (position, value) pairs, one write port, one registered read port.
module svdp_list_mem
	import svdp_pkg::*;
#(
	parameter int DEPTH = 256,
	parameter int AW = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  pair_t         wdata,
	input  logic [AW-1:0] raddr,
	output pair_t         rdata
);

	pair_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

### hw/rtl/svdp_mac.sv
// Registered multiplier and 48-bit accumulator with match counter.
module svdp_mac
	import svdp_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  mac_ctl_t                ctl,
	input  logic [VAL_W-1:0]        va,
	input  logic [VAL_W-1:0]        vb,
	output logic signed [ACC_W-1:0] acc,
	output logic [MCNT_W-1:0]       match_cnt
);

	logic signed [PROD_W-1:0] prod_s1;
	logic                     fire_s1;
	logic signed [ACC_W-1:0]  acc_q;
	logic [MCNT_W-1:0]        match_q;

	always_ff @(posedge clk) begin
		prod_s1 <= $signed(va) * $signed(vb);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fire_s1 <= 1'b0;
		end else begin
			fire_s1 <= ctl.fire;
		end
	end

	// count wraps at 9 bits, same as masking the full count
	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			acc_q   <= '0;
			match_q <= '0;
		end else if (fire_s1) begin
			acc_q   <= acc_q + ACC_W'(prod_s1);
			match_q <= match_q + MCNT_W'(1);
		end
	end

	assign acc       = acc_q;
	assign match_cnt = match_q;

endmodule
